FILE: rtl/gdpt_pkg.sv
// shared constants and codes for the greedy distance point thinning core
// no dependencies

package gdpt_pkg;

  localparam int unsigned MaxKept    = 1024;
  localparam int unsigned Dimensions = 4;

  localparam int unsigned CoordW     = 16;
  localparam int unsigned IndexW     = 16;
  localparam int unsigned CutoffW    = 36;
  localparam int unsigned KeptTotalW = 11;

  localparam int unsigned CountW = $clog2(MaxKept + 1);
  localparam int unsigned AddrW  = $clog2(MaxKept);
  localparam int unsigned PointW = Dimensions * CoordW;
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned SumW   = SqW + $clog2(Dimensions);

  localparam logic ReqSeed = 1'b0;
  localparam logic ReqTest = 1'b1;

endpackage

FILE: rtl/gdpt_req_if.sv
// request channel: one point per transaction
// depends on gdpt_pkg

interface gdpt_req_if import gdpt_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [IndexW-1:0]        point_index;
  logic signed [CoordW-1:0] coord_0;
  logic signed [CoordW-1:0] coord_1;
  logic signed [CoordW-1:0] coord_2;
  logic signed [CoordW-1:0] coord_3;

  modport source (
    output valid, req_type, point_index, coord_0, coord_1, coord_2, coord_3,
    input  ready
  );

  modport sink (
    input  valid, req_type, point_index, coord_0, coord_1, coord_2, coord_3,
    output ready
  );

endinterface

FILE: rtl/gdpt_rsp_if.sv
// response channel: one result per request transaction
// depends on gdpt_pkg

interface gdpt_rsp_if import gdpt_pkg::*; ();

  logic                  valid;
  logic                  ready;
  logic [IndexW-1:0]     result_index;
  logic                  accepted;
  logic                  store_full;
  logic [KeptTotalW-1:0] kept_total;

  modport source (
    output valid, result_index, accepted, store_full, kept_total,
    input  ready
  );

  modport sink (
    input  valid, result_index, accepted, store_full, kept_total,
    output ready
  );

endinterface

FILE: rtl/greedy_distance_point_thinning_core.sv
// top level of the greedy distance point thinning core
// depends on gdpt_pkg, gdpt_req_if, gdpt_rsp_if and gdpt_ram

// Points arrive on req_i, one per transaction, and each gives exactly one
// transaction on rsp_o with its index, the accepted and store_full flags and
// the number of stored points after it. A seed point is stored without a test
// unless the store is full; a test point is stored only if the store is not
// full and no stored point lies at a squared distance below cutoff_squared.
// cfg_we_i/cfg_wdata_i write cutoff_squared; the user must do this only while
// idle, the core does not enforce it. req_i.ready is high only while the core
// is idle; one point is in work at a time. A seed, a point that meets a full
// store and a test point against an empty store go from idle straight to the
// done state. A test point reads the stored points one per cycle from the
// point memory through a two stage distance unit (four lane square, then sum
// and compare); a close point stops the scan early. Reset clears the stored
// count and the cutoff; the point memory needs no clearing. When rsp_o is
// stalled the result waits in its output register and a finished point waits
// in the core until the register frees.

module greedy_distance_point_thinning_core import gdpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CutoffW-1:0] cfg_wdata_i,
  gdpt_req_if.sink           req_i,
  gdpt_rsp_if.source         rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CutoffW-1:0]    cutoff_q;
  logic [CountW-1:0]     count_q;
  logic [IndexW-1:0]     idx_q;
  logic [CoordW-1:0]     coord_q [Dimensions];
  logic [CoordW-1:0]     coord_in [4];
  logic                  acc_q, full_q, hit_q, issue_done_q;
  logic [AddrW-1:0]      scan_addr_q;
  logic                  rd_vld_q, sq_vld_q;
  logic [SqW-1:0]        sq_q [Dimensions];
  logic [SqW-1:0]        sq_d [Dimensions];
  logic [SumW-1:0]       sum;
  logic                  close;
  logic                  issue;
  logic                  req_hs;
  logic                  out_load;
  logic                  store_is_full;
  logic [CountW-1:0]     count_d;
  logic [PointW-1:0]     wdata;
  logic [PointW-1:0]     rdata;
  logic [AddrW-1:0]      last_addr;

  logic                  rsp_valid_q;
  logic [IndexW-1:0]     rsp_index_q;
  logic                  rsp_acc_q, rsp_full_q;
  logic [KeptTotalW-1:0] rsp_total_q;

  assign coord_in[0] = req_i.coord_0;
  assign coord_in[1] = req_i.coord_1;
  assign coord_in[2] = req_i.coord_2;
  assign coord_in[3] = req_i.coord_3;

  assign req_i.ready   = (state_q == S_IDLE);
  assign req_hs        = req_i.valid && req_i.ready;
  assign store_is_full = (count_q == CountW'(MaxKept));
  assign out_load      = (state_q == S_DONE) && (!rsp_valid_q || rsp_o.ready);
  assign issue         = (state_q == S_SCAN) && !issue_done_q && !hit_q;
  assign last_addr     = AddrW'(count_q - CountW'(1));
  assign count_d       = acc_q ? count_q + CountW'(1) : count_q;

  always_comb begin
    wdata = '0;
    for (int d = 0; d < Dimensions; d++) begin
      wdata[d*CoordW +: CoordW] = coord_q[d];
    end
  end

  gdpt_ram #(
    .Width (PointW),
    .Depth (MaxKept)
  ) u_points (
    .clk_i   (clk_i),
    .we_i    (out_load && acc_q),
    .waddr_i (AddrW'(count_q)),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (scan_addr_q),
    .rdata_o (rdata)
  );

  // per lane squared difference
  always_comb begin
    logic signed [CoordW:0] diff;
    logic [CoordW-1:0]      mag;
    for (int d = 0; d < Dimensions; d++) begin
      diff = {coord_q[d][CoordW-1], coord_q[d]}
           - {rdata[d*CoordW+CoordW-1], rdata[d*CoordW +: CoordW]};
      mag  = diff[CoordW] ? CoordW'(-diff) : CoordW'(diff);
      sq_d[d] = SqW'(mag * mag);
    end
  end

  always_comb begin
    sum = '0;
    for (int d = 0; d < Dimensions; d++) begin
      sum = sum + SumW'(sq_q[d]);
    end
  end

  assign close = (CutoffW'(sum) < cutoff_q);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      for (int d = 0; d < Dimensions; d++) begin
        sq_q[d] <= sq_d[d];
      end
    end
    if (req_hs) begin
      idx_q <= req_i.point_index;
      for (int d = 0; d < Dimensions; d++) begin
        coord_q[d] <= coord_in[d];
      end
    end
    if (out_load) begin
      rsp_index_q <= idx_q;
      rsp_acc_q   <= acc_q;
      rsp_full_q  <= full_q;
      rsp_total_q <= KeptTotalW'(count_d);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_hs) begin
          if (store_is_full || req_i.req_type == ReqSeed || count_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((issue_done_q || hit_q) && !rd_vld_q && !sq_vld_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cutoff_q     <= '0;
      count_q      <= '0;
      acc_q        <= 1'b0;
      full_q       <= 1'b0;
      hit_q        <= 1'b0;
      issue_done_q <= 1'b0;
      scan_addr_q  <= '0;
      rd_vld_q     <= 1'b0;
      sq_vld_q     <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      sq_vld_q <= rd_vld_q;
      if (cfg_we_i) begin
        cutoff_q <= cfg_wdata_i;
      end
      if (req_hs) begin
        full_q       <= store_is_full;
        acc_q        <= !store_is_full;
        hit_q        <= 1'b0;
        issue_done_q <= 1'b0;
        scan_addr_q  <= '0;
      end
      if (issue) begin
        scan_addr_q <= scan_addr_q + AddrW'(1);
        if (scan_addr_q == last_addr) begin
          issue_done_q <= 1'b1;
        end
      end
      if (sq_vld_q && close) begin
        hit_q <= 1'b1;
      end
      if (state_q == S_SCAN && state_d == S_DONE) begin
        acc_q <= !hit_q;
      end
      if (out_load) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_index = rsp_index_q;
  assign rsp_o.accepted     = rsp_acc_q;
  assign rsp_o.store_full   = rsp_full_q;
  assign rsp_o.kept_total   = rsp_total_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxKept))
    else $error("stored count above capacity");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> (!rd_vld_q && !sq_vld_q && !issue))
    else $error("ready while the distance pipeline is busy");

  a_full_not_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && full_q |-> !acc_q)
    else $error("point stored into a full store");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && acc_q |=> count_q == $past(count_q) + CountW'(1))
    else $error("stored count did not advance on a stored point");

  a_no_scan_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> CountW'(scan_addr_q) < count_q)
    else $error("scan read beyond the stored points");
`endif

endmodule

FILE: rtl/gdpt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies

module gdpt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
